@@ rtl/pebs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the particle Euler/bounce step block.
package pebs_pkg;

  localparam int WORD_W    = 32;
  localparam int DT_W      = 17;
  localparam int CFG_IDX_W = 1;
  localparam int OP_W      = 5;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUND   = 1'b1;

  // Request opcodes
  localparam logic OPC_LAUNCH = 1'b0;
  localparam logic OPC_TICK   = 1'b1;

  localparam logic [WORD_W-1:0] LIFETIME_RST = 32'h0001_0000;

  // Micro-op sequence of one tick; non-issuing slots: NONE, WAIT, CHK, END
  typedef enum logic [OP_W-1:0] {
    OP_NONE, OP_GRAV, OP_DRAG, OP_WAIT,
    OP_VX, OP_VY, OP_VZ,
    OP_PX, OP_PY, OP_PZ,
    OP_CHK, OP_BVY, OP_KX, OP_KZ,
    OP_SX, OP_SY, OP_SZ,
    OP_RX, OP_RY, OP_RZ,
    OP_END
  } op_t;

  typedef struct packed {
    logic acc;       // request accepted this cycle
    logic run;       // accepted request needs the integration sequence
    logic bounce;    // position y below ground
    logic out_free;  // result register can take a new result
  } seq_in_t;

  typedef struct packed {
    logic idle;
    logic fin;       // capture result this cycle
    op_t  issue_op;
    op_t  wb_op;
  } ctrl_t;

endpackage

@@ rtl/pebs_if.sv @@
`timescale 1ns / 1ps
// Request and result channel interfaces.
interface pebs_in_if;
  import pebs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic [DT_W-1:0]          time_step;
  logic signed [WORD_W-1:0] start_pos_x;
  logic signed [WORD_W-1:0] start_pos_y;
  logic signed [WORD_W-1:0] start_pos_z;
  logic signed [WORD_W-1:0] start_vel_x;
  logic signed [WORD_W-1:0] start_vel_y;
  logic signed [WORD_W-1:0] start_vel_z;
  logic signed [WORD_W-1:0] start_spin_x;
  logic signed [WORD_W-1:0] start_spin_y;
  logic signed [WORD_W-1:0] start_spin_z;

  modport source (
    output valid, opcode, time_step,
    output start_pos_x, start_pos_y, start_pos_z,
    output start_vel_x, start_vel_y, start_vel_z,
    output start_spin_x, start_spin_y, start_spin_z,
    input  ready
  );

  modport sink (
    input  valid, opcode, time_step,
    input  start_pos_x, start_pos_y, start_pos_z,
    input  start_vel_x, start_vel_y, start_vel_z,
    input  start_spin_x, start_spin_y, start_spin_z,
    output ready
  );
endinterface

interface pebs_out_if;
  import pebs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] pos_x;
  logic signed [WORD_W-1:0] pos_y;
  logic signed [WORD_W-1:0] pos_z;
  logic signed [WORD_W-1:0] rot_x;
  logic signed [WORD_W-1:0] rot_y;
  logic signed [WORD_W-1:0] rot_z;
  logic                     alive;

  modport source (
    output valid, pos_x, pos_y, pos_z, rot_x, rot_y, rot_z, alive,
    input  ready
  );

  modport sink (
    input  valid, pos_x, pos_y, pos_z, rot_x, rot_y, rot_z, alive,
    output ready
  );
endinterface

@@ rtl/pebs_mul.sv @@
`timescale 1ns / 1ps
// Shared fixed-point multiply-accumulate unit: registered product, then round, add or subtract, saturate.
module pebs_mul #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic signed [pebs_pkg::WORD_W:0]   a,
  input  logic signed [pebs_pkg::WORD_W-1:0] b,
  input  logic signed [pebs_pkg::WORD_W-1:0] addend,
  input  logic                               neg,
  output logic signed [pebs_pkg::WORD_W-1:0] res
);
  import pebs_pkg::*;

  localparam int PROD_W = 2 * WORD_W + 1;
  localparam int SUM_W  = PROD_W + 1;
  localparam logic signed [PROD_W-1:0] HALF  = PROD_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0]  S_MAX = SUM_W'(32'sh7FFF_FFFF);
  localparam logic signed [SUM_W-1:0]  S_MIN = -(SUM_W'(1) <<< (WORD_W - 1));

  logic signed [PROD_W-1:0] prod_r;
  logic signed [WORD_W-1:0] addend_r;
  logic                     neg_r;
  logic signed [PROD_W-1:0] rnd;
  logic signed [SUM_W-1:0]  sum;

  always_ff @(posedge clk) begin
    prod_r   <= PROD_W'(a) * PROD_W'(b);
    addend_r <= addend;
    neg_r    <= neg;
  end

  // floor((p + half) / 2^F): round half up
  assign rnd = (prod_r + HALF) >>> FRAC_BITS;

  always_comb begin
    sum = SUM_W'(addend_r) + (neg_r ? -SUM_W'(rnd) : SUM_W'(rnd));
    if (sum > S_MAX) begin
      res = S_MAX[WORD_W-1:0];
    end else if (sum < S_MIN) begin
      res = S_MIN[WORD_W-1:0];
    end else begin
      res = sum[WORD_W-1:0];
    end
  end

endmodule

@@ rtl/pebs_seq.sv @@
`timescale 1ns / 1ps
// Sequencer: walks the micro-op list of one tick and hands results to the output stage.
module pebs_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  pebs_pkg::seq_in_t req,
  output pebs_pkg::ctrl_t   ctrl
);
  import pebs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_FIN  = 3'b100
  } seq_state_t;

  seq_state_t state_r, state_nxt;
  op_t        op_r, op_nxt;
  op_t        wb_op_r;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    case (state_r)
      S_IDLE: begin
        if (req.acc) begin
          if (req.run) begin
            state_nxt = S_RUN;
            op_nxt    = OP_GRAV;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_RUN: begin
        case (op_r)
          OP_CHK: begin
            op_nxt = req.bounce ? OP_BVY : OP_RX;
          end
          OP_END: begin
            op_nxt    = OP_NONE;
            state_nxt = S_FIN;
          end
          default: begin
            op_nxt = op_t'(op_r + OP_W'(1));
          end
        endcase
      end
      S_FIN: begin
        if (req.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
        op_nxt    = OP_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_NONE;
      wb_op_r <= OP_NONE;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      wb_op_r <= op_r;
    end
  end

  assign ctrl.idle     = (state_r == S_IDLE);
  assign ctrl.fin      = (state_r == S_FIN) && req.out_free;
  assign ctrl.issue_op = op_r;
  assign ctrl.wb_op    = wb_op_r;

endmodule

@@ rtl/particle_euler_bounce_step.sv @@
`timescale 1ns / 1ps
// Top level: one debris particle, explicit Euler with ground bounce, Q(32-F).F fixed point.
// Launch, tick of an inactive particle, or expiring tick: no integration; the sequencer goes
//   from idle to its finish state, loads the result register when free, then returns to idle.
// Live tick: the integration sequence, longer with a ground hit; the one shared multiplier
//   issues one product per cycle outside the non-issuing slots, writeback in the next cycle.
// Synchronous active-low reset: particle inactive, all vectors and age zero, lifetime 1.0 at FRAC_BITS 16.
module particle_euler_bounce_step #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  pebs_in_if.sink                              in_chan,
  pebs_out_if.source                           out_chan,
  input  logic                                 cfg_we,
  input  logic [pebs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pebs_pkg::WORD_W-1:0]          cfg_wdata
);
  import pebs_pkg::*;

  // Fixed-point constants, rounded to nearest at FRAC_BITS
  localparam int ONE_I = 1 << FRAC_BITS;
  localparam logic signed [WORD_W:0]   A_NGRAV = (WORD_W + 1)'(-(22 * ONE_I));
  localparam logic signed [WORD_W:0]   A_DRAG  = (WORD_W + 1)'(((6 << FRAC_BITS) + 5) / 10);
  localparam logic signed [WORD_W-1:0] B_REST  = WORD_W'(((35 << FRAC_BITS) + 50) / 100);
  localparam logic signed [WORD_W-1:0] B_KEEP  = WORD_W'(((6 << FRAC_BITS) + 5) / 10);
  localparam logic signed [WORD_W-1:0] B_HALF  = WORD_W'(1 << (FRAC_BITS - 1));
  localparam logic signed [WORD_W-1:0] SNAP_C  = WORD_W'(((3 << FRAC_BITS) + 5) / 10);
  localparam logic signed [WORD_W-1:0] ADD_ONE = WORD_W'(ONE_I);

  // Particle state
  logic signed [WORD_W-1:0] pos_r[3], pos_nxt[3];
  logic signed [WORD_W-1:0] vel_r[3], vel_nxt[3];
  logic signed [WORD_W-1:0] spin_r[3], spin_nxt[3];
  logic signed [WORD_W-1:0] rot_r[3], rot_nxt[3];
  logic [WORD_W-1:0]        age_r, age_nxt;
  logic                     active_r, active_nxt;

  // Per-tick working registers
  logic [DT_W-1:0]          dt_r, dt_nxt;
  logic [FRAC_BITS:0]       f_r, f_nxt;       // drag factor, 0..1.0

  // Config
  logic [WORD_W-1:0]        lifetime_r;
  logic signed [WORD_W-1:0] ground_r;

  // Result register
  logic signed [WORD_W-1:0] out_pos_r[3];
  logic signed [WORD_W-1:0] out_rot_r[3];
  logic                     out_alive_r;
  logic                     out_valid_r;

  // Shared unit operands
  logic signed [WORD_W:0]   mul_a;
  logic signed [WORD_W-1:0] mul_b;
  logic signed [WORD_W-1:0] mul_add;
  logic                     mul_neg;
  logic signed [WORD_W-1:0] mul_res;
  logic signed [WORD_W-1:0] vy_snap;
  logic signed [WORD_W-1:0] dt_b;

  logic                     in_acc;
  logic                     is_launch;
  logic [WORD_W:0]          age_sum;
  logic [WORD_W-1:0]        age_sat;
  logic                     expire;

  seq_in_t                  seq_in;
  ctrl_t                    ctrl;

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  assign in_chan.ready = ctrl.idle;
  assign in_acc        = in_chan.valid & in_chan.ready;
  assign is_launch     = (in_chan.opcode == OPC_LAUNCH);

  // Age saturates at all-ones; expiry checked on the updated age
  assign age_sum = {1'b0, age_r} + (WORD_W + 1)'(in_chan.time_step);
  assign age_sat = age_sum[WORD_W] ? '1 : age_sum[WORD_W-1:0];
  assign expire  = (age_sat >= lifetime_r);

  assign seq_in.acc      = in_acc;
  assign seq_in.run      = !is_launch && active_r && !expire;
  assign seq_in.bounce   = (pos_r[1] < ground_r);
  assign seq_in.out_free = !out_valid_r || out_chan.ready;

  pebs_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (seq_in),
    .ctrl  (ctrl)
  );

  // ---------------------------------------------------------------------------
  // Operand select for the issuing micro-op
  // ---------------------------------------------------------------------------
  assign dt_b = WORD_W'(dt_r);

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_add = '0;
    mul_neg = 1'b0;
    case (ctrl.issue_op)
      OP_GRAV: begin  // vy - G*dt; G*dt is exact so -G*dt rounds the same
        mul_a   = A_NGRAV;
        mul_b   = dt_b;
        mul_add = vel_r[1];
      end
      OP_DRAG: begin  // 1 - drag*dt, clamped at writeback
        mul_a   = A_DRAG;
        mul_b   = dt_b;
        mul_add = ADD_ONE;
        mul_neg = 1'b1;
      end
      OP_VX: begin
        mul_a = {vel_r[0][WORD_W-1], vel_r[0]};
        mul_b = WORD_W'(f_r);
      end
      OP_VY: begin
        mul_a = {vel_r[1][WORD_W-1], vel_r[1]};
        mul_b = WORD_W'(f_r);
      end
      OP_VZ: begin
        mul_a = {vel_r[2][WORD_W-1], vel_r[2]};
        mul_b = WORD_W'(f_r);
      end
      OP_PX: begin
        mul_a   = {vel_r[0][WORD_W-1], vel_r[0]};
        mul_b   = dt_b;
        mul_add = pos_r[0];
      end
      OP_PY: begin
        mul_a   = {vel_r[1][WORD_W-1], vel_r[1]};
        mul_b   = dt_b;
        mul_add = pos_r[1];
      end
      OP_PZ: begin
        mul_a   = {vel_r[2][WORD_W-1], vel_r[2]};
        mul_b   = dt_b;
        mul_add = pos_r[2];
      end
      OP_BVY: begin  // reflect: (-vy) * restitution, 33 bits so -min fits
        mul_a = -{vel_r[1][WORD_W-1], vel_r[1]};
        mul_b = B_REST;
      end
      OP_KX: begin
        mul_a = {vel_r[0][WORD_W-1], vel_r[0]};
        mul_b = B_KEEP;
      end
      OP_KZ: begin
        mul_a = {vel_r[2][WORD_W-1], vel_r[2]};
        mul_b = B_KEEP;
      end
      OP_SX: begin
        mul_a = {spin_r[0][WORD_W-1], spin_r[0]};
        mul_b = B_HALF;
      end
      OP_SY: begin
        mul_a = {spin_r[1][WORD_W-1], spin_r[1]};
        mul_b = B_HALF;
      end
      OP_SZ: begin
        mul_a = {spin_r[2][WORD_W-1], spin_r[2]};
        mul_b = B_HALF;
      end
      OP_RX: begin
        mul_a   = {spin_r[0][WORD_W-1], spin_r[0]};
        mul_b   = dt_b;
        mul_add = rot_r[0];
      end
      OP_RY: begin
        mul_a   = {spin_r[1][WORD_W-1], spin_r[1]};
        mul_b   = dt_b;
        mul_add = rot_r[1];
      end
      OP_RZ: begin
        mul_a   = {spin_r[2][WORD_W-1], spin_r[2]};
        mul_b   = dt_b;
        mul_add = rot_r[2];
      end
      default: ;
    endcase
  end

  pebs_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .addend (mul_add),
    .neg    (mul_neg),
    .res    (mul_res)
  );

  // Small rebounds snap to rest
  assign vy_snap = (mul_res < SNAP_C && mul_res > -SNAP_C) ? '0 : mul_res;

  // ---------------------------------------------------------------------------
  // State update: request load, ground clamp, writeback of the unit
  // ---------------------------------------------------------------------------
  always_comb begin
    pos_nxt    = pos_r;
    vel_nxt    = vel_r;
    spin_nxt   = spin_r;
    rot_nxt    = rot_r;
    age_nxt    = age_r;
    active_nxt = active_r;
    f_nxt      = f_r;
    dt_nxt     = in_acc ? in_chan.time_step : dt_r;

    if (in_acc) begin
      if (is_launch) begin
        pos_nxt[0]  = in_chan.start_pos_x;
        pos_nxt[1]  = in_chan.start_pos_y;
        pos_nxt[2]  = in_chan.start_pos_z;
        vel_nxt[0]  = in_chan.start_vel_x;
        vel_nxt[1]  = in_chan.start_vel_y;
        vel_nxt[2]  = in_chan.start_vel_z;
        spin_nxt[0] = in_chan.start_spin_x;
        spin_nxt[1] = in_chan.start_spin_y;
        spin_nxt[2] = in_chan.start_spin_z;
        for (int i = 0; i < 3; i++) begin
          rot_nxt[i] = '0;
        end
        age_nxt    = '0;
        active_nxt = 1'b1;
      end else if (active_r) begin
        age_nxt = age_sat;
        if (expire) begin
          active_nxt = 1'b0;
        end
      end
    end

    // Ground hit: height clamps once all positions are in
    if (ctrl.issue_op == OP_CHK && seq_in.bounce) begin
      pos_nxt[1] = ground_r;
    end

    case (ctrl.wb_op)
      OP_GRAV: vel_nxt[1] = mul_res;
      OP_DRAG: f_nxt      = mul_res[WORD_W-1] ? '0 : mul_res[FRAC_BITS:0];
      OP_VX:   vel_nxt[0] = mul_res;
      OP_VY:   vel_nxt[1] = mul_res;
      OP_VZ:   vel_nxt[2] = mul_res;
      OP_PX:   pos_nxt[0] = mul_res;
      OP_PY:   pos_nxt[1] = mul_res;
      OP_PZ:   pos_nxt[2] = mul_res;
      OP_BVY:  vel_nxt[1] = vy_snap;
      OP_KX:   vel_nxt[0] = mul_res;
      OP_KZ:   vel_nxt[2] = mul_res;
      OP_SX:   spin_nxt[0] = mul_res;
      OP_SY:   spin_nxt[1] = mul_res;
      OP_SZ:   spin_nxt[2] = mul_res;
      OP_RX:   rot_nxt[0] = mul_res;
      OP_RY:   rot_nxt[1] = mul_res;
      OP_RZ:   rot_nxt[2] = mul_res;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        pos_r[i]  <= '0;
        vel_r[i]  <= '0;
        spin_r[i] <= '0;
        rot_r[i]  <= '0;
      end
      age_r    <= '0;
      active_r <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      vel_r    <= vel_nxt;
      spin_r   <= spin_nxt;
      rot_r    <= rot_nxt;
      age_r    <= age_nxt;
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dt_r <= dt_nxt;
    f_r  <= f_nxt;
  end

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lifetime_r <= LIFETIME_RST;
      ground_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LIFETIME: lifetime_r <= cfg_wdata;
        CFG_GROUND:   ground_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: holds a result until taken while the next request runs
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.fin) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fin) begin
      out_pos_r   <= pos_r;
      out_rot_r   <= rot_r;
      out_alive_r <= active_r;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.pos_x = out_pos_r[0];
  assign out_chan.pos_y = out_pos_r[1];
  assign out_chan.pos_z = out_pos_r[2];
  assign out_chan.rot_x = out_rot_r[0];
  assign out_chan.rot_y = out_rot_r[1];
  assign out_chan.rot_z = out_rot_r[2];
  assign out_chan.alive = out_alive_r;

endmodule
